[rtl/x86d_pkg.sv]
// ----------------------------------------------------------------------------
// x86d_pkg: shared types and constants of the x86 real-mode decoder
// Phase, status, segment, rep, rel and config codes, the opcode plan type and cls_t.
// ----------------------------------------------------------------------------
`default_nettype none
package x86d_pkg;

  typedef enum logic [2:0] {
    PH_START = 3'd0,
    PH_OPC   = 3'd1,
    PH_EXT   = 3'd2,
    PH_MODRM = 3'd3,
    PH_DISP  = 3'd4,
    PH_IMM   = 3'd5
  } phase_t;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_BADOP = 3'd1;
  localparam logic [2:0] ST_BADREP = 3'd2;
  localparam logic [2:0] ST_FPU   = 3'd3;
  localparam logic [2:0] ST_INT   = 3'd4;
  localparam logic [2:0] ST_FAR   = 3'd5;
  localparam logic [2:0] ST_TRUNC = 3'd6;

  localparam logic [2:0] SEG_NONE = 3'd0;
  localparam logic [2:0] SEG_ES = 3'd1;
  localparam logic [2:0] SEG_CS = 3'd2;
  localparam logic [2:0] SEG_SS = 3'd3;
  localparam logic [2:0] SEG_DS = 3'd4;

  localparam logic [1:0] REP_NONE = 2'd0;
  localparam logic [1:0] REP_NE = 2'd1;
  localparam logic [1:0] REP_E = 2'd2;

  localparam logic [1:0] REL_NONE = 2'd0;
  localparam logic [1:0] REL_8 = 2'd1;
  localparam logic [1:0] REL_16 = 2'd2;

  localparam logic [1:0] CFG_START = 2'd0;
  localparam logic [1:0] CFG_EXTRA = 2'd1;
  localparam logic [1:0] CFG_386 = 2'd2;

  typedef struct packed {
    logic       want_modrm;
    logic [1:0] imm_len;
    logic [1:0] rel;
    logic [1:0] disp_len;
    logic [2:0] mem_seg;
  } plan_t;

  typedef struct packed {
    plan_t      plan;
    logic [2:0] status;
  } cls_t;

endpackage
`default_nettype wire

[rtl/x86d_classify.sv]
// ----------------------------------------------------------------------------
// x86d_classify: one-byte opcode table
// Gives the plan of trailing parts and the status for a main opcode.
// ----------------------------------------------------------------------------
`default_nettype none
module x86d_classify (
  input  wire logic          extra,
  input  wire logic [7:0]    op,
  output x86d_pkg::cls_t     cls
);

  logic [2:0] xs;

  always_comb begin
    xs = extra ? x86d_pkg::ST_OK : x86d_pkg::ST_BADOP;
    cls = '0;
    if (op < 8'h40) begin
      if (op[2:0] < 3'd4) cls.plan.want_modrm = 1'b1;
      else if (op[2:0] == 3'd4) cls.plan.imm_len = 2'd1;
      else if (op[2:0] == 3'd5) cls.plan.imm_len = 2'd2;
      else if (op[2:0] == 3'd7 && op >= 8'h20) cls.status = xs;
    end else if (op < 8'h60) begin
      cls.status = x86d_pkg::ST_OK;
    end else if (op <= 8'h61) begin
      cls.status = xs;
    end else if (op <= 8'h67) begin
      cls.status = x86d_pkg::ST_BADOP;
    end else if (op <= 8'h6F) begin
      priority case (op)
        8'h68: cls.plan.imm_len = 2'd2;
        8'h69: begin cls.plan.want_modrm = 1'b1; cls.plan.imm_len = 2'd2; end
        8'h6A: cls.plan.imm_len = 2'd1;
        8'h6B: begin cls.plan.want_modrm = 1'b1; cls.plan.imm_len = 2'd1; end
        default: begin cls.plan.mem_seg = x86d_pkg::SEG_DS; cls.status = xs; end
      endcase
    end else if (op <= 8'h7F) begin
      cls.plan.rel = x86d_pkg::REL_8;
    end else if (op <= 8'h87) begin
      cls.plan.want_modrm = 1'b1;
      if (op == 8'h81) cls.plan.imm_len = 2'd2;
      else if (op <= 8'h83) cls.plan.imm_len = 2'd1;
      else cls.status = xs;
    end else if (op <= 8'h8F) begin
      cls.plan.want_modrm = 1'b1;
    end else if (op <= 8'h99) begin
      cls.status = x86d_pkg::ST_OK;
    end else if (op == 8'h9A) begin
      cls.status = x86d_pkg::ST_FAR;
    end else if (op == 8'h9B) begin
      cls.status = x86d_pkg::ST_FPU;
    end else if (op <= 8'h9F) begin
      cls.status = xs;
    end else if (op <= 8'hA3) begin
      cls.plan.disp_len = 2'd2;
      cls.plan.mem_seg = x86d_pkg::SEG_DS;
    end else if (op <= 8'hA7) begin
      cls.plan.mem_seg = x86d_pkg::SEG_DS;
      cls.status = (extra || op <= 8'hA5) ? x86d_pkg::ST_OK : x86d_pkg::ST_BADOP;
    end else if (op == 8'hA8) begin
      cls.plan.imm_len = 2'd1; cls.status = xs;
    end else if (op == 8'hA9) begin
      cls.plan.imm_len = 2'd2; cls.status = xs;
    end else if (op <= 8'hAF) begin
      cls.plan.mem_seg = x86d_pkg::SEG_DS;
      cls.status = (extra || op <= 8'hAD) ? x86d_pkg::ST_OK : x86d_pkg::ST_BADOP;
    end else if (op <= 8'hB7) begin
      cls.plan.imm_len = 2'd1;
    end else if (op <= 8'hBF) begin
      cls.plan.imm_len = 2'd2;
    end else begin
      unique case (op)
        8'hC0, 8'hC1, 8'hC6: begin
          cls.plan.want_modrm = 1'b1; cls.plan.imm_len = 2'd1;
        end
        8'hC7: begin cls.plan.want_modrm = 1'b1; cls.plan.imm_len = 2'd2; end
        8'hC2, 8'hCA: cls.plan.imm_len = 2'd2;
        8'hC3, 8'hC9, 8'hCB, 8'hFC, 8'hFD: cls.status = x86d_pkg::ST_OK;
        8'hC4, 8'hC5, 8'hD0, 8'hD1, 8'hD2, 8'hD3, 8'hF6, 8'hF7, 8'hFE, 8'hFF:
          cls.plan.want_modrm = 1'b1;
        8'hC8: cls.plan.imm_len = 2'd3;
        8'hCC, 8'hCD, 8'hCE, 8'hCF, 8'hF1: cls.status = x86d_pkg::ST_INT;
        8'hD4, 8'hD5: begin cls.plan.imm_len = 2'd1; cls.status = xs; end
        8'hE0, 8'hE1, 8'hE2: begin cls.plan.rel = x86d_pkg::REL_8; cls.status = xs; end
        8'hE3, 8'hEB: cls.plan.rel = x86d_pkg::REL_8;
        8'hE4, 8'hE5, 8'hE6, 8'hE7: begin cls.plan.imm_len = 2'd1; cls.status = xs; end
        8'hE8, 8'hE9: cls.plan.rel = x86d_pkg::REL_16;
        8'hEA: cls.status = x86d_pkg::ST_FAR;
        8'hD8, 8'hD9, 8'hDA, 8'hDB, 8'hDC, 8'hDD, 8'hDE, 8'hDF:
          cls.status = x86d_pkg::ST_FPU;
        default: cls.status = xs;
      endcase
    end
  end

endmodule
`default_nettype wire

[rtl/x86_16bit_instruction_decoder.sv]
// ----------------------------------------------------------------------------
// x86_16bit_instruction_decoder: byte-serial 8086 instruction decoder
// Walks prefixes, opcode, modrm, displacement and immediates one byte a beat.
// ----------------------------------------------------------------------------
// the record of an instruction is registered and appears in the cycle after its final byte
// throughput: one code byte per cycle while in_stall is low, set by the single-pass phase machine
// the output register refills in the cycle it is taken, so no bubble
// reset: current address and start address 0, phase expects prefix or opcode,
// both enables off, no record pending
`default_nettype none
module x86_16bit_instruction_decoder (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_code_byte,
  input  wire logic        in_last_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      out_insn_addr,
  output logic [7:0]       out_opcode,
  output logic [7:0]       out_ext_opcode,
  output logic [7:0]       out_modrm,
  output logic [2:0]       out_segment,
  output logic [1:0]       out_rep_prefix,
  output logic signed [15:0] out_displacement,
  output logic signed [15:0] out_immediate,
  output logic signed [7:0]  out_immediate_second,
  output logic [15:0]      out_branch_target,
  output logic [2:0]       out_status,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  // configuration
  logic [15:0] start_address_r;
  logic        extra_r, ext386_r;
  logic        cfg_start_wr;

  // decode state
  x86d_pkg::phase_t phase_r, phase_nxt;
  logic [15:0] cur_addr_r, cur_addr_nxt;
  logic [15:0] saddr_r, saddr_nxt;
  logic [7:0]  opc_r, opc_nxt, ext_r, ext_nxt, modrm_r, modrm_nxt;
  logic [2:0]  seg_r, seg_nxt;
  logic [1:0]  rep_r, rep_nxt;
  logic [15:0] disp_r, disp_nxt;
  logic [23:0] imm_r, imm_nxt;
  logic [2:0]  left_r, left_nxt;
  x86d_pkg::plan_t plan_r, plan_nxt;

  // record register
  logic        ov_r, ov_nxt;
  logic [15:0] o_addr_r, o_disp_r, o_imm_r, o_tgt_r;
  logic [7:0]  o_opc_r, o_ext_r, o_modrm_r, o_imm2_r;
  logic [2:0]  o_seg_r, o_st_r;
  logic [1:0]  o_rep_r;

  x86d_pkg::cls_t cls;
  logic        acc;
  logic        emit;
  logic [2:0]  st;
  logic [15:0] next_a;

  // stall only when a record is waiting and not taken this cycle
  assign in_stall = ov_r && out_stall;
  assign acc = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign cfg_start_wr = cfg_valid && (cfg_index == x86d_pkg::CFG_START);

  // a new record wins over the one leaving in the same cycle
  assign ov_nxt = (acc && emit) ? 1'b1 : (ov_r && !out_stall) ? 1'b0 : ov_r;

  x86d_classify u_cls (.extra(extra_r), .op(in_code_byte), .cls(cls));

  always_comb begin
    logic [7:0]  b;
    logic [2:0]  reg_f;
    logic [1:0]  idx;
    logic [2:0]  n;
    logic        done;
    b = in_code_byte;
    reg_f = b[5:3];
    phase_nxt = phase_r;
    saddr_nxt = saddr_r; opc_nxt = opc_r; ext_nxt = ext_r; modrm_nxt = modrm_r;
    seg_nxt = seg_r; rep_nxt = rep_r; disp_nxt = disp_r; imm_nxt = imm_r;
    left_nxt = left_r; plan_nxt = plan_r;
    emit = 1'b0; st = x86d_pkg::ST_OK; done = 1'b0; idx = 2'd0; n = 3'd0;
    next_a = cur_addr_r + 16'd1;
    if (phase_r == x86d_pkg::PH_START) begin
      saddr_nxt = cur_addr_r; opc_nxt = '0; ext_nxt = '0; modrm_nxt = '0;
      seg_nxt = x86d_pkg::SEG_NONE; rep_nxt = x86d_pkg::REP_NONE;
      disp_nxt = '0; imm_nxt = '0; left_nxt = '0; plan_nxt = '0;
    end
    unique case (phase_r)
      x86d_pkg::PH_START, x86d_pkg::PH_OPC: begin
        phase_nxt = x86d_pkg::PH_OPC;
        priority if (b == 8'h26) seg_nxt = x86d_pkg::SEG_ES;
        else if (b == 8'h2E) seg_nxt = x86d_pkg::SEG_CS;
        else if (b == 8'h36) seg_nxt = x86d_pkg::SEG_SS;
        else if (b == 8'h3E) seg_nxt = x86d_pkg::SEG_DS;
        else if (b == 8'hF2) rep_nxt = x86d_pkg::REP_NE;
        else if (b == 8'hF3) rep_nxt = x86d_pkg::REP_E;
        else begin
          opc_nxt = b;
          if (rep_nxt != x86d_pkg::REP_NONE &&
              !((b >= 8'h6C && b <= 8'h6F) || (b >= 8'hA4 && b <= 8'hA7) ||
                (b >= 8'hAA && b <= 8'hAF))) begin
            emit = 1'b1; st = x86d_pkg::ST_BADREP;
          end else if (b == 8'h0F) begin
            plan_nxt = '0;
            if (ext386_r) phase_nxt = x86d_pkg::PH_EXT;
            else begin emit = 1'b1; st = x86d_pkg::ST_BADOP; end
          end else begin
            plan_nxt = cls.plan;
            if (cls.status != x86d_pkg::ST_OK) begin
              emit = 1'b1; st = cls.status;
            end else done = 1'b1;
          end
        end
      end
      x86d_pkg::PH_EXT: begin
        ext_nxt = b;
        if (b[7:4] == 4'h8) begin plan_nxt.rel = x86d_pkg::REL_16; done = 1'b1; end
        else if (b[7:4] == 4'h9) begin plan_nxt.want_modrm = 1'b1; done = 1'b1; end
        else begin emit = 1'b1; st = x86d_pkg::ST_BADOP; end
      end
      x86d_pkg::PH_MODRM: begin
        modrm_nxt = b;
        if ((opc_r == 8'hFE && ext_r == 8'h00 && reg_f > 3'd1) ||
            (opc_r == 8'hFF && reg_f == 3'd7) ||
            ((opc_r == 8'hF6 || opc_r == 8'hF7) && reg_f < 3'd2 && !extra_r)) begin
          emit = 1'b1; st = x86d_pkg::ST_BADOP;
        end else begin
          if ((opc_r == 8'hF6 || opc_r == 8'hF7) && reg_f < 3'd2)
            plan_nxt.imm_len = (opc_r == 8'hF6) ? 2'd1 : 2'd2;
          if (b[7:6] == 2'b11) plan_nxt.disp_len = 2'd0;
          else if (b[7:6] == 2'b00 && b[2:0] == 3'd6) begin
            plan_nxt.disp_len = 2'd2; plan_nxt.mem_seg = x86d_pkg::SEG_DS;
          end else begin
            plan_nxt.mem_seg = (b[2:0] == 3'd2 || b[2:0] == 3'd3 || b[2:0] == 3'd6)
                             ? x86d_pkg::SEG_SS : x86d_pkg::SEG_DS;
            plan_nxt.disp_len = (b[7:6] == 2'b01) ? 2'd1 :
                                (b[7:6] == 2'b10) ? 2'd2 : 2'd0;
          end
          // go straight to displacement if any, else to immediates or emit the record
          if (plan_nxt.disp_len != 2'd0) begin
            phase_nxt = x86d_pkg::PH_DISP; left_nxt = {1'b0, plan_nxt.disp_len};
          end else begin
            n = {1'b0, plan_nxt.imm_len} + {1'b0, plan_nxt.rel};
            if (n == 3'd0) emit = 1'b1;
            else begin phase_nxt = x86d_pkg::PH_IMM; left_nxt = n; end
          end
        end
      end
      x86d_pkg::PH_DISP: begin
        idx = 2'(({1'b0, plan_r.disp_len} - left_r) & 3'd1);
        if (idx[0]) disp_nxt[15:8] = disp_r[15:8] | b;
        else disp_nxt[7:0] = disp_r[7:0] | b;
        left_nxt = left_r - 3'd1;
        if (left_nxt == 3'd0) begin
          n = {1'b0, plan_r.imm_len} + {1'b0, plan_r.rel};
          if (n == 3'd0) emit = 1'b1;
          else begin phase_nxt = x86d_pkg::PH_IMM; left_nxt = n; end
        end
      end
      x86d_pkg::PH_IMM: begin
        n = ({1'b0, plan_r.imm_len} + {1'b0, plan_r.rel}) - left_r;
        idx = (n > 3'd2) ? 2'd2 : n[1:0];
        unique case (idx)
          2'd0: imm_nxt[7:0] = imm_r[7:0] | b;
          2'd1: imm_nxt[15:8] = imm_r[15:8] | b;
          default: imm_nxt[23:16] = imm_r[23:16] | b;
        endcase
        left_nxt = left_r - 3'd1;
        if (left_nxt == 3'd0) emit = 1'b1;
      end
      default: begin
        emit = 1'b1; st = x86d_pkg::ST_BADOP;
      end
    endcase
    // plan entry after opcode or 0F xx
    if (done) begin
      if (plan_nxt.want_modrm) phase_nxt = x86d_pkg::PH_MODRM;
      else if (plan_nxt.disp_len != 2'd0) begin
        phase_nxt = x86d_pkg::PH_DISP; left_nxt = {1'b0, plan_nxt.disp_len};
      end else begin
        n = {1'b0, plan_nxt.imm_len} + {1'b0, plan_nxt.rel};
        if (n == 3'd0) emit = 1'b1;
        else begin phase_nxt = x86d_pkg::PH_IMM; left_nxt = n; end
      end
    end
    if (!emit && in_last_byte) begin emit = 1'b1; st = x86d_pkg::ST_TRUNC; end
    if (emit) phase_nxt = x86d_pkg::PH_START;
    cur_addr_nxt = in_last_byte ? start_address_r : next_a;
    if (in_last_byte) phase_nxt = x86d_pkg::PH_START;
  end

  // record fields from the updated state
  logic [2:0]  r_seg;
  logic [15:0] r_disp, r_imm, r_tgt;
  logic [7:0]  r_imm2;
  always_comb begin
    r_seg = seg_nxt; r_disp = '0; r_imm = '0; r_tgt = '0; r_imm2 = '0;
    if (st == x86d_pkg::ST_OK) begin
      if (r_seg == x86d_pkg::SEG_NONE) r_seg = plan_nxt.mem_seg;
      if (plan_nxt.disp_len == 2'd1) r_disp = {{8{disp_nxt[7]}}, disp_nxt[7:0]};
      else if (plan_nxt.disp_len == 2'd2) r_disp = disp_nxt;
      if (plan_nxt.rel == x86d_pkg::REL_8)
        r_tgt = next_a + {{8{imm_nxt[7]}}, imm_nxt[7:0]};
      else if (plan_nxt.rel == x86d_pkg::REL_16) r_tgt = next_a + imm_nxt[15:0];
      else if (plan_nxt.imm_len == 2'd1) r_imm = {{8{imm_nxt[7]}}, imm_nxt[7:0]};
      else if (plan_nxt.imm_len >= 2'd2) r_imm = imm_nxt[15:0];
      if (plan_nxt.imm_len == 2'd3) r_imm2 = imm_nxt[23:16];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_address_r <= '0; extra_r <= 1'b0; ext386_r <= 1'b0;
      cur_addr_r <= '0; phase_r <= x86d_pkg::PH_START; ov_r <= 1'b0;
      saddr_r <= '0; opc_r <= '0; ext_r <= '0; modrm_r <= '0;
      seg_r <= '0; rep_r <= '0; disp_r <= '0; imm_r <= '0; left_r <= '0;
      plan_r <= '0;
    end else begin
      ov_r <= ov_nxt;
      if (acc) begin
        // a start address write takes over address and phase
        if (!cfg_start_wr) begin
          phase_r <= phase_nxt; cur_addr_r <= cur_addr_nxt;
        end
        saddr_r <= saddr_nxt; opc_r <= opc_nxt; ext_r <= ext_nxt;
        modrm_r <= modrm_nxt; seg_r <= seg_nxt; rep_r <= rep_nxt;
        disp_r <= disp_nxt; imm_r <= imm_nxt; left_r <= left_nxt;
        plan_r <= plan_nxt;
      end
      if (cfg_valid) begin
        unique case (cfg_index)
          x86d_pkg::CFG_START: begin
            start_address_r <= cfg_data;
            cur_addr_r <= cfg_data;
            phase_r <= x86d_pkg::PH_START;
          end
          x86d_pkg::CFG_EXTRA: extra_r <= cfg_data[0];
          x86d_pkg::CFG_386: ext386_r <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  // record payload, loaded when a beat produces a record
  always_ff @(posedge clk) begin
    if (acc && emit) begin
      o_addr_r <= saddr_nxt; o_opc_r <= opc_nxt; o_ext_r <= ext_nxt;
      o_modrm_r <= modrm_nxt; o_seg_r <= r_seg; o_rep_r <= rep_nxt;
      o_disp_r <= r_disp; o_imm_r <= r_imm; o_imm2_r <= r_imm2;
      o_tgt_r <= r_tgt; o_st_r <= st;
    end
  end

  assign out_valid = ov_r;
  assign out_insn_addr = o_addr_r;
  assign out_opcode = o_opc_r;
  assign out_ext_opcode = o_ext_r;
  assign out_modrm = o_modrm_r;
  assign out_segment = o_seg_r;
  assign out_rep_prefix = o_rep_r;
  assign out_displacement = o_disp_r;
  assign out_immediate = o_imm_r;
  assign out_immediate_second = o_imm2_r;
  assign out_branch_target = o_tgt_r;
  assign out_status = o_st_r;

  // a stalled record is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && out_stall) |-> !acc) else $error("record overwritten");
  // a last byte always yields a record
  a_last_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_last_byte) |=> ov_r) else $error("last byte without record");
  // last byte returns phase to start
  a_last_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_last_byte && !cfg_valid) |=> phase_r == x86d_pkg::PH_START)
    else $error("phase not reset after last byte");

endmodule
`default_nettype wire
